### design/bicubic_row_interpolator_defines.svh
// Assertion macros for the bicubic row interpolator.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef BICUBIC_ROW_INTERPOLATOR_DEFINES_SVH
`define BICUBIC_ROW_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BRI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/bri_pkg.sv
// Shared types and constants of the bicubic row interpolator.
// Used by bri_lane, bri_horner and bicubic_row_interpolator; no dependencies.
`default_nettype none

package bri_pkg;

    localparam int NUM_PTS = 4;

    typedef enum logic [1:0] {
        COEF_C = 2'd0,
        COEF_Q = 2'd1,
        COEF_L = 2'd2,
        COEF_K = 2'd3
    } t_coef;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LANE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic  step_en;
        t_coef sel;
    } t_horner_ctl;

    // Doubled Catmull-Rom coefficient weights, one row per lane (c, q, l, k).
    localparam logic signed [3:0] LANE_WEIGHTS [NUM_PTS][NUM_PTS] = '{
        '{-4'sd1,  4'sd3, -4'sd3,  4'sd1},
        '{ 4'sd2, -4'sd5,  4'sd4, -4'sd1},
        '{-4'sd1,  4'sd0,  4'sd1,  4'sd0},
        '{ 4'sd0,  4'sd2,  4'sd0,  4'sd0}
    };

endpackage

`default_nettype wire

### design/bicubic_row_interpolator.sv
// Top level of the Catmull-Rom bicubic interpolator: row sequencer, partial store, output register.
// Depends on bri_pkg, bri_lane, bri_horner and bicubic_row_interpolator_defines.svh.
//
//  channel  | dir | tdata fields (low bit first)                         | tlast | tuser
//  s_axis   | in  | tap_left, tap_center, tap_right, tap_far_right,     |  -    |  -
//           |     | horiz_fraction, vert_fraction                        |       |
//  m_axis   | out | pixel_value                                          |  -    |  -
//
// A row item passes from acceptance through the lane state, the Horner states MUL1, MUL2
// and MUL3 on the shared multiplier and the finishing state before the next acceptance.
// The fourth row of a group adds a second, vertical pass through the same states.
// A finished pixel waits in the output register; the next item is taken meanwhile.
// Only the vertical finish stalls, while the output register is still full.
// Synchronous active-low reset clears the sequencer, row count and output valid.
`default_nettype none
`include "bicubic_row_interpolator_defines.svh"

module bicubic_row_interpolator #(
    parameter int SAMPLE_BITS   = 8,
    parameter int FRACTION_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // tap_left, tap_center, tap_right, tap_far_right, horiz_fraction, vert_fraction
    input  logic [((4*SAMPLE_BITS+2*FRACTION_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // pixel_value
    output logic [((SAMPLE_BITS+6+7)/8)*8-1:0] o_m_axis_tdata
);
    import bri_pkg::*;

    localparam int SW  = SAMPLE_BITS;
    localparam int FW  = FRACTION_BITS;
    localparam int PW  = SW + 10;
    localparam int EW  = SW + 15;
    localparam int OW  = SW + 6;
    localparam int ODW = ((SW + 6 + 7) / 8) * 8;

    localparam logic signed [EW-1:0] PART_MAX = EW'((64'sd1 <<< (PW - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] PART_MIN = EW'(-(64'sd1 <<< (PW - 1)));
    localparam logic signed [EW-1:0] OUT_MAX  = EW'(64'sd3 * (64'sd1 <<< (SW + 3)) - 64'sd1);
    localparam logic signed [EW-1:0] OUT_MIN  = EW'(-(64'sd1 <<< (SW + 3)));

    t_state               r_state;
    t_state               n_state;
    logic [1:0]           r_phase;
    logic                 r_vert;
    logic signed [PW-1:0] r_pts  [NUM_PTS];
    logic signed [PW-1:0] r_part [3];
    logic [FW-1:0]        r_th;
    logic [FW-1:0]        r_tv;
    logic                 r_out_valid;
    logic [OW-1:0]        r_pixel;

    logic                 s_accept;
    logic                 lane_load;
    logic                 store_row;
    logic                 start_vert;
    logic                 out_wr;
    t_horner_ctl          hctl;
    logic signed [EW-1:0] w_coef [NUM_PTS];
    logic signed [EW-1:0] w_acc;
    logic signed [EW-1:0] row_sh;
    logic signed [EW-1:0] pix_sh;
    logic signed [PW-1:0] w_row;
    logic signed [EW-1:0] w_pix;
    logic [SW-1:0]        taps [NUM_PTS];

    always_comb begin
        for (int j = 0; j < NUM_PTS; j++) begin
            taps[j] = i_s_axis_tdata[j*SW +: SW];
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_PTS; g++) begin : g_lane
            bri_lane #(
                .LANE (g),
                .PW   (PW),
                .EW   (EW)
            ) u_lane (
                .i_clk  (i_clk),
                .i_load (lane_load),
                .i_pts  (r_pts),
                .o_coef (w_coef[g])
            );
        end
    endgenerate

    bri_horner #(
        .EW (EW),
        .FW (FW)
    ) u_horner (
        .i_clk  (i_clk),
        .i_ctl  (hctl),
        .i_coef (w_coef),
        .i_frac (r_vert ? r_tv : r_th),
        .o_acc  (w_acc)
    );

    // Finish: round and saturate the Horner result for a row or for the pixel.
    always_comb begin
        row_sh = (w_acc + EW'(1)) >>> 1;
        pix_sh = (w_acc + EW'(16)) >>> 5;
        priority if (row_sh > PART_MAX) begin
            w_row = PART_MAX[PW-1:0];
        end else if (row_sh < PART_MIN) begin
            w_row = PART_MIN[PW-1:0];
        end else begin
            w_row = row_sh[PW-1:0];
        end
        priority if (pix_sh > OUT_MAX) begin
            w_pix = OUT_MAX;
        end else if (pix_sh < OUT_MIN) begin
            w_pix = OUT_MIN;
        end else begin
            w_pix = pix_sh;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = ST_LANE;
                end
            end
            ST_LANE: n_state = ST_MUL1;
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_MUL3;
            ST_MUL3: n_state = ST_FIN;
            ST_FIN: begin
                if (!r_vert) begin
                    n_state = (r_phase == 2'd3) ? ST_LANE : ST_IDLE;
                end else if (!r_out_valid || i_m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        lane_load       = 1'b0;
        hctl.step_en    = 1'b0;
        hctl.sel        = COEF_Q;
        store_row       = 1'b0;
        start_vert      = 1'b0;
        out_wr          = 1'b0;
        unique case (r_state)
            ST_IDLE: o_s_axis_tready = 1'b1;
            ST_LANE: lane_load = 1'b1;
            ST_MUL1: begin
                hctl.step_en = 1'b1;
                hctl.sel     = COEF_Q;
            end
            ST_MUL2: begin
                hctl.step_en = 1'b1;
                hctl.sel     = COEF_L;
            end
            ST_MUL3: begin
                hctl.step_en = 1'b1;
                hctl.sel     = COEF_K;
            end
            ST_FIN: begin
                store_row  = !r_vert && (r_phase != 2'd3);
                start_vert = !r_vert && (r_phase == 2'd3);
                out_wr     = r_vert && (!r_out_valid || i_m_axis_tready);
            end
            default: o_s_axis_tready = 1'b0;
        endcase
    end

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= 2'd0;
            r_vert      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_accept) begin
                r_vert <= 1'b0;
            end else if (start_vert) begin
                r_vert <= 1'b1;
            end
            if (store_row) begin
                r_phase <= r_phase + 2'd1;
            end else if (out_wr) begin
                r_phase <= 2'd0;
            end
            if (out_wr) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            for (int j = 0; j < NUM_PTS; j++) begin
                r_pts[j] <= $signed({2'b00, taps[j], 8'h00});
            end
            r_th <= i_s_axis_tdata[NUM_PTS*SW +: FW];
            r_tv <= i_s_axis_tdata[NUM_PTS*SW+FW +: FW];
        end else if (start_vert) begin
            r_pts[0] <= r_part[0];
            r_pts[1] <= r_part[1];
            r_pts[2] <= r_part[2];
            r_pts[3] <= w_row;
        end
        if (store_row) begin
            r_part[r_phase] <= w_row;
        end
        if (out_wr) begin
            r_pixel <= w_pix[OW-1:0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = ODW'(r_pixel);

    `BRI_ASSERT_NEXT(a_accept_starts_row, i_clk, i_rst_n, s_accept,
        (r_state == ST_LANE) && !r_vert, "accepted item did not start a row pass")
    `BRI_ASSERT_NOW(a_vert_after_four_rows, i_clk, i_rst_n, (r_state == ST_FIN) && r_vert,
        r_phase == 2'd3, "vertical pass without four stored rows")
    `BRI_ASSERT_NEXT(a_hold_when_full, i_clk, i_rst_n,
        (r_state == ST_FIN) && r_vert && r_out_valid && !i_m_axis_tready,
        (r_state == ST_FIN) && o_m_axis_tvalid, "pixel finish did not hold on full output")
    `BRI_ASSERT_NEXT(a_mul3_to_fin, i_clk, i_rst_n, r_state == ST_MUL3,
        r_state == ST_FIN, "Horner sequence did not reach finish")

endmodule

`default_nettype wire

### design/bri_lane.sv
// One coefficient lane: weighted sum of the four points, registered.
// Depends on bri_pkg for the lane weight table.
`default_nettype none

module bri_lane #(
    parameter int LANE = 0,
    parameter int PW   = 18,
    parameter int EW   = 23
) (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic signed [PW-1:0] i_pts [bri_pkg::NUM_PTS],
    output logic signed [EW-1:0] o_coef
);
    import bri_pkg::*;

    logic signed [EW-1:0] r_coef;
    logic signed [EW-1:0] n_coef;

    always_comb begin
        logic signed [EW-1:0] acc;
        acc = '0;
        for (int j = 0; j < NUM_PTS; j++) begin
            acc = acc + (EW'(i_pts[j]) * EW'(LANE_WEIGHTS[LANE][j]));
        end
        n_coef = acc;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_coef <= n_coef;
        end
    end

    assign o_coef = r_coef;

endmodule

`default_nettype wire

### design/bri_horner.sv
// Merging stage: Horner evaluation of the lane coefficients, one multiply per cycle while the step enable is set.
// Depends on bri_pkg for the control struct and coefficient codes.
`default_nettype none

module bri_horner #(
    parameter int EW = 23,
    parameter int FW = 8
) (
    input  logic                     i_clk,
    input  bri_pkg::t_horner_ctl     i_ctl,
    input  logic signed [EW-1:0]     i_coef [bri_pkg::NUM_PTS],
    input  logic        [FW-1:0]     i_frac,
    output logic signed [EW-1:0]     o_acc
);
    import bri_pkg::*;

    localparam int PRW = EW + FW + 1;
    localparam logic signed [PRW-1:0] HALF = PRW'(1) <<< (FW - 1);

    logic signed [EW-1:0]  r_acc;
    logic signed [EW-1:0]  n_acc;
    logic signed [EW-1:0]  mul_a;
    logic signed [FW:0]    frac_s;
    logic signed [PRW-1:0] prod;
    logic signed [PRW-1:0] prod_sh;

    always_comb begin
        mul_a   = (i_ctl.sel == COEF_Q) ? i_coef[COEF_C] : r_acc;
        frac_s  = $signed({1'b0, i_frac});
        prod    = PRW'(mul_a) * PRW'(frac_s);
        prod_sh = (prod + HALF) >>> FW;
        n_acc   = i_coef[i_ctl.sel] + prod_sh[EW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

### tb/tb_bicubic_row_interpolator.sv
// Testbench for bicubic_row_interpolator: streams groups of four row items and checks each pixel
// against a fixed-point Catmull-Rom predictor kept in step with every accepted item.
// Depends only on the bicubic_row_interpolator RTL.
`default_nettype none

module tb_bicubic_row_interpolator;

    localparam int     SAMPLE_BITS   = 8;
    localparam int     FRACTION_BITS = 8;
    localparam int     PIXEL_BITS    = SAMPLE_BITS + 6;
    localparam longint PART_MAX      = (longint'(1) << (SAMPLE_BITS + 9)) - 1;
    localparam longint PART_MIN      = -(longint'(1) << (SAMPLE_BITS + 9));
    localparam longint PIXEL_MAX     = 3 * (longint'(1) << (SAMPLE_BITS + 3)) - 1;
    localparam longint PIXEL_MIN     = -(longint'(1) << (SAMPLE_BITS + 3));

    typedef struct packed {
        logic [FRACTION_BITS-1:0] vert_fraction;
        logic [FRACTION_BITS-1:0] horiz_fraction;
        logic [SAMPLE_BITS-1:0]   tap_far_right;
        logic [SAMPLE_BITS-1:0]   tap_right;
        logic [SAMPLE_BITS-1:0]   tap_center;
        logic [SAMPLE_BITS-1:0]   tap_left;
    } t_row_item;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_JITTER,
        RX_HOLDOFF
    } t_rx_mode;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // tap_left, tap_center, tap_right, tap_far_right, horiz_fraction, vert_fraction
    logic [47:0] i_s_axis_tdata  = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // pixel_value
    logic [15:0] o_m_axis_tdata;

    t_rx_mode                rx_mode     = RX_OPEN;
    int                      stall_left  = 0;
    int                      errors      = 0;
    int                      rows_held   = 0;
    longint                  row_store [3];
    logic [PIXEL_BITS-1:0]   pixel_queue [$];

    bicubic_row_interpolator #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint round_half_up(longint x, int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // doubled Catmull-Rom value of four Q.8 points, Horner form in t (Q0.8)
    function automatic longint catmull_rom2(longint p0, longint p1, longint p2, longint p3,
                                            longint t);
        longint c;
        longint q;
        longint l;
        longint k;
        longint e1;
        longint e2;
        c  = -p0 + 3 * p1 - 3 * p2 + p3;
        q  = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        l  = p2 - p0;
        k  = 2 * p1;
        e1 = q + round_half_up(c * t, FRACTION_BITS);
        e2 = l + round_half_up(e1 * t, FRACTION_BITS);
        return k + round_half_up(e2 * t, FRACTION_BITS);
    endfunction

    task automatic predict_row(input t_row_item r);
        longint row;
        longint pix;
        row = catmull_rom2(longint'(r.tap_left) * 256, longint'(r.tap_center) * 256,
                           longint'(r.tap_right) * 256, longint'(r.tap_far_right) * 256,
                           longint'(r.horiz_fraction));
        row = clamp(round_half_up(row, 1), PART_MIN, PART_MAX);
        if (rows_held < 3) begin
            row_store[rows_held] = row;
            rows_held++;
        end else begin
            pix = catmull_rom2(row_store[0], row_store[1], row_store[2], row,
                               longint'(r.vert_fraction));
            pix = clamp(round_half_up(pix, 5), PIXEL_MIN, PIXEL_MAX);
            pixel_queue.push_back(pix[PIXEL_BITS-1:0]);
            rows_held = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [PIXEL_BITS-1:0] got,
                                   input logic [PIXEL_BITS-1:0] want);
        $display("tb: %s: got %0d expected %0d", what, $signed(got), $signed(want));
        errors++;
    endtask

    task automatic push_row(input t_row_item r);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= r;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_row(r);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= 48'({$urandom, $urandom});
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] pick_field();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_row_item random_row();
        t_row_item r;
        r.tap_left       = pick_field();
        r.tap_center     = pick_field();
        r.tap_right      = pick_field();
        r.tap_far_right  = pick_field();
        r.horiz_fraction = pick_field();
        r.vert_fraction  = pick_field();
        return r;
    endfunction

    function automatic t_row_item make_row(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c, input logic [7:0] d,
                                           input logic [7:0] th, input logic [7:0] tv);
        t_row_item r;
        r.tap_left       = a;
        r.tap_center     = b;
        r.tap_right      = c;
        r.tap_far_right  = d;
        r.horiz_fraction = th;
        r.vert_fraction  = tv;
        return r;
    endfunction

    always @(posedge i_clk) begin
        case (rx_mode)
            RX_OPEN:   i_m_axis_tready <= 1'b1;
            RX_JITTER: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    i_m_axis_tready <= 1'b0;
                end else if ($urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(1, 24);
                    i_m_axis_tready <= 1'b0;
                end else begin
                    i_m_axis_tready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin : check_pixels
        logic [PIXEL_BITS-1:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pixel_queue.size() == 0) begin
                report_mismatch("pixel with no row group pending",
                                o_m_axis_tdata[PIXEL_BITS-1:0], '0);
            end else begin
                want = pixel_queue.pop_front();
                if (o_m_axis_tdata[PIXEL_BITS-1:0] !== want) begin
                    report_mismatch("pixel_value", o_m_axis_tdata[PIXEL_BITS-1:0], want);
                end
            end
        end
    end

    task automatic test_directed_corners();
        t_row_item r;
        rx_mode = RX_OPEN;
        for (int g = 0; g < 6; g++) begin
            for (int k = 0; k < 4; k++) begin
                case (g)
                    0: r = make_row(pick_field(), pick_field(), pick_field(), pick_field(),
                                    8'd0, 8'd0);
                    1: r = make_row(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255);
                    2: r = make_row(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd128);
                    3: r = (k == 1 || k == 2) ?
                           make_row(8'd0, 8'd0, 8'd255, 8'd255, 8'd128, 8'd128) :
                           make_row(8'd255, 8'd255, 8'd0, 8'd0, 8'd128, 8'd128);
                    4: r = k[0] ? make_row(8'd255, 8'd0, 8'd255, 8'd0, 8'd1, 8'd1) :
                                  make_row(8'd0, 8'd255, 8'd0, 8'd255, 8'd254, 8'd1);
                    default: r = make_row(pick_field(), pick_field(), pick_field(),
                                          pick_field(), 8'd128, 8'd255);
                endcase
                push_row(r);
            end
        end
    endtask

    task automatic test_bursty_rows(input int n);
        int burst_left;
        rx_mode    = RX_JITTER;
        burst_left = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            push_row(random_row());
            burst_left--;
            if (burst_left == 0) begin
                idle_cycles($urandom_range(0, 9));
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    task automatic test_output_backpressure(input int n);
        rx_mode = RX_HOLDOFF;
        for (int i = 0; i < n; i++) begin
            push_row(random_row());
            if ($urandom_range(0, 5) == 0) idle_cycles($urandom_range(1, 2));
        end
    endtask

    task automatic test_extreme_values(input int n);
        t_row_item r;
        rx_mode = RX_OPEN;
        for (int i = 0; i < n; i++) begin
            r = random_row();
            r.tap_left      = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            r.tap_center    = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            r.tap_right     = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            r.tap_far_right = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            push_row(r);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_corners();
        test_bursty_rows(400);
        test_output_backpressure(200);
        test_extreme_values(80);
        idle_cycles(1);
        rx_mode = RX_JITTER;
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
